// File: rtl/tsmr_pkg.sv
// Package: shared constants and types for the tape storage mean retrieval unit.
`default_nettype none
package tsmr_pkg;
  localparam int MaxPrograms  = 64;
  localparam int MaxTapes     = 16;
  localparam int LengthBits   = 16;
  localparam int FractionBits = 8;
  localparam int AddrBits     = $clog2(MaxPrograms);
  localparam int CountBits    = $clog2(MaxPrograms + 1);
  localparam int TapeBits     = $clog2(MaxTapes);
  localparam int TapeCntBits  = 5;
  localparam int MeanBits     = 30;
  localparam int PrefixBits   = LengthBits + AddrBits;
  localparam int TotalBits    = PrefixBits + AddrBits;
  localparam int SumBits      = MeanBits + TapeBits + 1;

  typedef struct packed {
    logic [LengthBits-1:0] length;
    logic                  last;
  } in_beat_t;

  typedef struct packed {
    logic [TapeBits-1:0] tape_index;
    logic [MeanBits-1:0] tape_mean;
    logic                tape_empty;
    logic [MeanBits-1:0] overall_mean;
    logic                dropped;
    logic                last;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/tsmr_ram.sv
// Generic RAM with one write port and one read port, registered read.
`default_nettype none
module tsmr_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/tsmr_fifo.sv
// Two-entry beat queue between the loader front and the run engine.
`default_nettype none
module tsmr_fifo import tsmr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_beat_t din_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output in_beat_t      dout_o,
  output logic          empty_o
);
  in_beat_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// File: rtl/tsmr_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tsmr_divider import tsmr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [SumBits-1:0]       dividend_i,
  input  wire logic [CountBits-1:0]     divisor_i,
  output logic                          done_o,
  output logic      [SumBits-1:0]       quot_o
);
  localparam int StepBits = $clog2(SumBits + 1);
  logic [SumBits-1:0]   quot_q;
  logic [CountBits:0]   rem_q;
  logic [CountBits-1:0] div_q;
  logic [StepBits-1:0]  step_q;
  logic                 busy_q, done_q;
  logic [CountBits:0]   trial;

  assign trial  = {rem_q[CountBits-1:0], quot_q[SumBits-1]};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        quot_q <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
        step_q <= StepBits'(SumBits);
      end else if (busy_q) begin
        if (trial >= {1'b0, div_q}) begin
          rem_q  <= trial - {1'b0, div_q};
          quot_q <= {quot_q[SumBits-2:0], 1'b1};
        end else begin
          rem_q  <= trial;
          quot_q <= {quot_q[SumBits-2:0], 1'b0};
        end
        step_q <= step_q - 1'b1;
        if (step_q == StepBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/tsmr_engine.sv
// Run engine: store, sort, deal, mean and result emission.
`default_nettype none
module tsmr_engine import tsmr_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [TapeCntBits-1:0] tape_count_i,
  input  wire logic                   empty_i,
  input  wire in_beat_t               beat_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  output res_t                        res_o,
  input  wire logic                   res_ready_i
);
  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_WT, ST_SORT_CMP, ST_SORT_WR, ST_SORT_PUT,
    ST_DEAL_RD, ST_DEAL_WT, ST_DEAL_ACC, ST_DIV, ST_DIV_WT, ST_EMIT
  } state_e;

  state_e                state_q;
  logic [CountBits-1:0]  count_q;
  logic                  ovf_q;
  logic [CountBits-1:0]  i_q;
  logic [AddrBits-1:0]   j_q;
  logic [LengthBits-1:0] v_q;
  logic [TapeBits-1:0]   tape_q, t_last_q;
  logic [PrefixBits-1:0] prefix_q [MaxTapes];
  logic [TotalBits-1:0]  total_q  [MaxTapes];
  logic [AddrBits:0]     items_q  [MaxTapes];
  logic [MeanBits-1:0]   mean_q   [MaxTapes];
  logic [SumBits-1:0]    sum_q;
  logic                  div_frac_q;
  logic                  div_overall_q;
  logic [SumBits-1:0]    int_q;
  logic                  out_valid_q;
  res_t                  out_q;

  logic                  we;
  logic [AddrBits-1:0]   waddr, raddr;
  logic [LengthBits-1:0] wdata, rdata;
  logic                  div_start, div_done;
  logic [SumBits-1:0]    div_a, div_q;
  logic [CountBits-1:0]  div_b;
  logic [TapeCntBits-1:0] t_sat;

  tsmr_ram #(.Width(LengthBits), .Depth(MaxPrograms)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  tsmr_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    if (tape_count_i == '0) begin
      t_sat = TapeCntBits'(1);
    end else if (tape_count_i > TapeCntBits'(MaxTapes)) begin
      t_sat = TapeCntBits'(MaxTapes);
    end else begin
      t_sat = tape_count_i;
    end
  end

  assign pop_o = (state_q == ST_LOAD) && !empty_i;

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AddrBits-1:0];
    wdata = beat_i.length;
    // key fetch for the next insertion is issued while still in ST_SORT_RD
    raddr = (state_q == ST_SORT_RD) ? i_q[AddrBits-1:0] : j_q;
    if (pop_o && count_q < CountBits'(MaxPrograms)) begin
      we = 1'b1;
    end else if (state_q == ST_SORT_WR) begin
      we    = rdata > v_q;
      waddr = AddrBits'(j_q + 1'b1);
      wdata = rdata;
    end else if (state_q == ST_SORT_PUT) begin
      we    = 1'b1;
      waddr = j_q;
      wdata = v_q;
    end
  end

  // Divider operand: integer part, then fraction, then overall mean.
  always_comb begin
    div_start = 1'b0;
    div_a     = {{(SumBits-TotalBits){1'b0}}, total_q[tape_q]};
    div_b     = items_q[tape_q];
    if (state_q == ST_DIV) begin
      if (div_overall_q) begin
        div_start = 1'b1;
        div_a     = sum_q;
        div_b     = CountBits'({1'b0, t_last_q} + 1'b1);
      end else if (items_q[tape_q] != '0) begin
        div_start = 1'b1;
        if (div_frac_q) begin
          div_a = SumBits'((total_q[tape_q] - TotalBits'(int_q * items_q[tape_q]))
                  << FractionBits);
        end
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      count_q       <= '0;
      ovf_q         <= 1'b0;
      i_q           <= '0;
      j_q           <= '0;
      v_q           <= '0;
      tape_q        <= '0;
      t_last_q      <= '0;
      sum_q         <= '0;
      div_frac_q    <= 1'b0;
      div_overall_q <= 1'b0;
      int_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
      for (int k = 0; k < MaxTapes; k++) begin
        prefix_q[k] <= '0;
        total_q[k]  <= '0;
        items_q[k]  <= '0;
        mean_q[k]   <= '0;
      end
    end else begin
      // ST_EMIT drives the valid itself
      if (out_valid_q && res_ready_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (pop_o) begin
            if (count_q < CountBits'(MaxPrograms)) begin
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (beat_i.last) begin
              t_last_q <= TapeBits'(t_sat - 1'b1);
              for (int k = 0; k < MaxTapes; k++) begin
                prefix_q[k] <= '0;
                total_q[k]  <= '0;
                items_q[k]  <= '0;
              end
              i_q     <= CountBits'(1);
              state_q <= ST_SORT_RD;
            end
          end
        end
        ST_SORT_RD: begin
          if (i_q >= count_q) begin
            j_q     <= '0;
            tape_q  <= '0;
            i_q     <= '0;
            state_q <= ST_DEAL_RD;
          end else begin
            j_q     <= i_q[AddrBits-1:0];
            state_q <= ST_SORT_WT;
          end
        end
        ST_SORT_WT: begin
          v_q     <= rdata;
          state_q <= ST_SORT_CMP;
        end
        ST_SORT_CMP: begin
          // j_q holds the hole; look at the entry below it
          if (j_q == '0) begin
            state_q <= ST_SORT_PUT;
          end else begin
            j_q     <= j_q - 1'b1;
            state_q <= ST_SORT_WR;
          end
        end
        ST_SORT_WR: begin
          // the read of j_q is registered; div_frac_q marks the wait for it
          if (!div_frac_q) begin
            div_frac_q <= 1'b1;
          end else begin
            div_frac_q <= 1'b0;
            if (rdata > v_q) begin
              state_q <= ST_SORT_CMP;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_SORT_PUT;
            end
          end
        end
        ST_SORT_PUT: begin
          i_q     <= i_q + 1'b1;
          state_q <= ST_SORT_RD;
        end
        ST_DEAL_RD: begin
          if (i_q >= count_q) begin
            tape_q  <= '0;
            sum_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            j_q     <= i_q[AddrBits-1:0];
            state_q <= ST_DEAL_WT;
          end
        end
        ST_DEAL_WT: begin
          state_q <= ST_DEAL_ACC;
        end
        ST_DEAL_ACC: begin
          prefix_q[tape_q] <= prefix_q[tape_q] + PrefixBits'(rdata);
          total_q[tape_q]  <= total_q[tape_q] + TotalBits'(prefix_q[tape_q])
                              + TotalBits'(rdata);
          items_q[tape_q]  <= items_q[tape_q] + 1'b1;
          tape_q  <= (tape_q == t_last_q) ? '0 : tape_q + 1'b1;
          i_q     <= i_q + 1'b1;
          state_q <= ST_DEAL_RD;
        end
        ST_DIV: begin
          if (div_start) begin
            state_q <= ST_DIV_WT;
          end else begin
            mean_q[tape_q] <= '0;
            if (tape_q == t_last_q) begin
              div_overall_q <= 1'b1;
            end else begin
              tape_q <= tape_q + 1'b1;
            end
          end
        end
        ST_DIV_WT: begin
          if (div_done) begin
            if (div_overall_q) begin
              div_overall_q <= 1'b0;
              int_q         <= div_q;
              tape_q        <= '0;
              state_q       <= ST_EMIT;
            end else if (!div_frac_q) begin
              int_q      <= div_q;
              div_frac_q <= 1'b1;
              state_q    <= ST_DIV;
            end else begin
              div_frac_q <= 1'b0;
              if (int_q > SumBits'((1 << (MeanBits - FractionBits)) - 1)) begin
                mean_q[tape_q] <= '1;
                sum_q <= sum_q + SumBits'({MeanBits{1'b1}});
              end else begin
                mean_q[tape_q] <= MeanBits'((int_q << FractionBits) + div_q);
                sum_q <= sum_q + ((int_q << FractionBits) + div_q);
              end
              if (tape_q == t_last_q) begin
                div_overall_q <= 1'b1;
              end else begin
                tape_q <= tape_q + 1'b1;
              end
              state_q <= ST_DIV;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || res_ready_i) begin
            out_valid_q        <= 1'b1;
            out_q.tape_index   <= tape_q;
            out_q.tape_mean    <= mean_q[tape_q];
            out_q.tape_empty   <= items_q[tape_q] == '0;
            out_q.overall_mean <= (tape_q == t_last_q) ? MeanBits'(int_q) : '0;
            out_q.dropped      <= ovf_q;
            out_q.last         <= tape_q == t_last_q;
            if (tape_q == t_last_q) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              tape_q <= tape_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/tape_storage_mean_retrieval_unit.sv
// Top level: tape storage mean retrieval unit.
// Run: a set of lengths is insertion sorted, dealt to the tapes, and each
// tape's mean is found by the serial divider, then the overall mean.
// Throughput: loading takes a beat a cycle until the run starts; results leave
// at one beat a cycle while m_axis_tready is high. The serial divider sets the per-tape cost.
// Reset: asynchronous, active low; tape count returns to 1, store is empty.
`default_nettype none
module tape_storage_mean_retrieval_unit import tsmr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,          // tape_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,        // program_length
  input  wire logic        s_axis_tlast,        // last_program
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,        // tape_index, tape_mean_time, tape_empty,
                                                // overall_mean_time, dropped_programs
  output logic             m_axis_tlast         // last_result
);
  logic [TapeCntBits-1:0] tape_count_q;
  logic                   full, empty, pop;
  in_beat_t               din, dout;
  res_t                   res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_count_q <= TapeCntBits'(1);
    end else if (cfg_valid_i) begin
      tape_count_q <= cfg_data_i;
    end
  end

  // front: queue decouples input beats from the run engine
  assign s_axis_tready = !full;
  assign din.length    = s_axis_tdata;
  assign din.last      = s_axis_tlast;

  tsmr_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(s_axis_tvalid && !full), .din_i(din), .full_o(full),
    .pop_i(pop), .dout_o(dout), .empty_o(empty)
  );

  tsmr_engine u_engine (
    .clk_i, .rst_ni, .tape_count_i(tape_count_q), .empty_i(empty), .beat_i(dout),
    .pop_o(pop), .res_valid_o(m_axis_tvalid), .res_o(res), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, res.dropped, res.overall_mean, res.tape_empty,
                         res.tape_mean, res.tape_index};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire
